@@ sv/async_hdlc_deframer_crc16_macros.svh @@
// ----------------------------------------------------------------------------
// async_hdlc_deframer_crc16 assertion macros
// shared property wrappers, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASYNC_HDLC_DEFRAMER_CRC16_MACROS_SVH
`define ASYNC_HDLC_DEFRAMER_CRC16_MACROS_SVH

// same-cycle implication
`define AHDLC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AHDLC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ahdlc_pkg.sv @@
// ----------------------------------------------------------------------------
// ahdlc_pkg
// constants and types of the async hdlc deframer with crc-16 check
// ----------------------------------------------------------------------------
package ahdlc_pkg;

	localparam int OCTET_W   = 8;
	localparam int LEN_W     = 11;
	localparam int CRC_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [OCTET_W-1:0] FLAG_OCTET = 8'h7E;
	localparam logic [OCTET_W-1:0] ESC_OCTET  = 8'h7D;
	localparam logic [OCTET_W-1:0] ESC_XOR    = 8'h20;
	localparam logic [CRC_W-1:0]   CRC_POLY   = 16'h8408;

	localparam logic [CRC_W-1:0] CRC_START_RST  = 16'hFFFF;
	localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 11'd256;
	localparam logic [LEN_W-1:0] FCS_LEN        = 11'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CRC_START  = 2'd0,
		REG_MAX_LENGTH = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic               has_byte;
		logic [OCTET_W-1:0] out_byte;
		logic               frame_end;
		logic               frame_good;
		logic               frame_abort;
		logic [LEN_W-1:0]   frame_len;
	} result_t;

endpackage

@@ sv/ahdlc_intf.sv @@
// ----------------------------------------------------------------------------
// ahdlc channel interfaces
// valid/ready channels for line octets, results and register writes
// ----------------------------------------------------------------------------
interface ahdlc_in_if import ahdlc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OCTET_W-1:0] in_octet;

	modport source (output valid, output in_octet, input ready);
	modport sink (input valid, input in_octet, output ready);
endinterface

interface ahdlc_out_if import ahdlc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               has_byte;
	logic [OCTET_W-1:0] out_byte;
	logic               frame_end;
	logic               frame_good;
	logic               frame_abort;
	logic [LEN_W-1:0]   frame_len;

	modport source (output valid, output has_byte, output out_byte, output frame_end,
		output frame_good, output frame_abort, output frame_len, input ready);
	modport sink (input valid, input has_byte, input out_byte, input frame_end,
		input frame_good, input frame_abort, input frame_len, output ready);
endinterface

interface ahdlc_cfg_if import ahdlc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/ahdlc_crc.sv @@
// ----------------------------------------------------------------------------
// ahdlc_crc
// one-byte update of the reflected crc-16, lsb first
// ----------------------------------------------------------------------------
module ahdlc_crc import ahdlc_pkg::*; (
	input  logic [CRC_W-1:0]   crc_in,
	input  logic [OCTET_W-1:0] byte_in,
	output logic [CRC_W-1:0]   crc_out
);

	always_comb begin
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-OCTET_W){1'b0}}, byte_in};
		for (int i = 0; i < OCTET_W; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

@@ sv/async_hdlc_deframer_crc16.sv @@
// a line octet is registered in the input stage, and its word then in the result register
// throughput: one line octet per cycle; the byte-wide crc update sets the path
// a result waiting on a stalled sink holds a producing input stage, which stalls the input
// reset: control state cleared, crc_start 0xffff, max_length 256, crc at 0xffff
// held octets are not reset; no clearing pass after reset
// ----------------------------------------------------------------------------
// async_hdlc_deframer_crc16
// removes byte stuffing, delays payload two octets and checks the crc-16 fcs
// ----------------------------------------------------------------------------
`include "async_hdlc_deframer_crc16_macros.svh"

module async_hdlc_deframer_crc16 import ahdlc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	ahdlc_in_if.sink      octets,
	ahdlc_out_if.source   results,
	ahdlc_cfg_if.sink     cfg
);

	// configuration
	logic [CRC_W-1:0] crc_start_q;
	logic [LEN_W-1:0] max_length_q;

	// frame state
	logic             esc_q;
	logic [LEN_W-1:0] pos_q;
	logic [CRC_W-1:0] crc_q;
	logic [OCTET_W-1:0] held0_q;
	logic [OCTET_W-1:0] held1_q;

	// input stage
	logic               valid_s1;
	logic [OCTET_W-1:0] octet_s1;

	// result register
	logic    out_valid_q;
	result_t res_q;

	// step logic
	logic               is_flag;
	logic               is_esc;
	logic               store;
	logic               emit;
	logic [OCTET_W-1:0] stored;
	logic [CRC_W-1:0]   crc_fed;
	logic [LEN_W-1:0]   pos_inc;
	logic               abort;
	logic               produce;
	logic               out_free;
	logic               go_s1;
	logic               in_ready;
	result_t            res_n;
	logic               esc_n;
	logic [LEN_W-1:0]   pos_n;
	logic [CRC_W-1:0]   crc_n;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_start_q  <= CRC_START_RST;
			max_length_q <= MAX_LENGTH_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CRC_START:  crc_start_q  <= cfg.data[CRC_W-1:0];
				REG_MAX_LENGTH: max_length_q <= cfg.data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	ahdlc_crc u_crc (
		.crc_in  (crc_q),
		.byte_in (held1_q),
		.crc_out (crc_fed)
	);

	always_comb begin
		is_flag = (octet_s1 == FLAG_OCTET);
		is_esc  = !esc_q && (octet_s1 == ESC_OCTET);
		store   = !is_flag && !is_esc;
		stored  = esc_q ? (octet_s1 ^ ESC_XOR) : octet_s1;
		emit    = store && (pos_q >= FCS_LEN);
		pos_inc = pos_q + 1'b1;
		abort   = store && (pos_inc >= max_length_q);
		produce = is_flag || emit || abort;
	end

	always_comb begin
		esc_n = esc_q;
		pos_n = pos_q;
		crc_n = crc_q;
		if (is_flag) begin
			esc_n = 1'b0;
			pos_n = '0;
			crc_n = crc_start_q;
		end else if (is_esc) begin
			esc_n = 1'b1;
		end else begin
			esc_n = 1'b0;
			if (abort) begin
				pos_n = '0;
				crc_n = crc_start_q;
			end else begin
				pos_n = pos_inc;
				if (emit) begin
					crc_n = crc_fed;
				end
			end
		end
	end

	always_comb begin
		res_n              = '0;
		res_n.has_byte     = emit;
		res_n.out_byte     = emit ? held1_q : '0;
		res_n.frame_abort  = abort;
		if (is_flag) begin
			res_n.frame_end    = 1'b1;
			res_n.frame_good   = !esc_q && (pos_q >= FCS_LEN) &&
				(crc_q == {held0_q, held1_q});
			res_n.frame_len    = pos_q;
		end
	end

	assign out_free = !out_valid_q || results.ready;
	assign go_s1    = valid_s1 && (!produce || out_free);
	assign in_ready = !valid_s1 || go_s1;
	assign octets.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= octets.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && octets.valid) begin
			octet_s1 <= octets.in_octet;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
			pos_q <= '0;
			crc_q <= CRC_START_RST;
		end else if (go_s1) begin
			esc_q <= esc_n;
			pos_q <= pos_n;
			crc_q <= crc_n;
		end
	end

	// shift the two-octet fcs window
	always_ff @(posedge clk) begin
		if (go_s1 && store) begin
			held1_q <= held0_q;
			held0_q <= stored;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && produce) begin
			res_q <= res_n;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.has_byte     = res_q.has_byte;
	assign results.out_byte     = res_q.out_byte;
	assign results.frame_end    = res_q.frame_end;
	assign results.frame_good   = res_q.frame_good;
	assign results.frame_abort  = res_q.frame_abort;
	assign results.frame_len    = res_q.frame_len;

	`AHDLC_ASSERT_NOW(a_end_excl, out_valid_q && res_q.frame_end, !res_q.frame_abort && !res_q.has_byte, "frame end mixed with payload or abort")
	`AHDLC_ASSERT_NOW(a_good_len, out_valid_q && res_q.frame_good, res_q.frame_end && (res_q.frame_len >= FCS_LEN), "good frame without end or fcs")
	`AHDLC_ASSERT_NEXT(a_flag_restart, go_s1 && is_flag, (pos_q == '0) && !esc_q, "flag did not restart the frame")
	`AHDLC_ASSERT_NOW(a_byte_zero, out_valid_q && !res_q.has_byte, res_q.out_byte == '0, "stray payload byte")
	`AHDLC_ASSERT_NEXT(a_stall_hold, out_valid_q && !results.ready, out_valid_q && $stable(res_q), "result changed under stall")

endmodule

@@ tb/tb_async_hdlc_deframer_crc16.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_async_hdlc_deframer_crc16
// feeds stuffed line octets and checks every delayed byte, frame-end and
// abort word against a directed table or a cycle-free predictor of the deframer, over several
// crc_start / max_length settings and idle patterns on both channels
// ----------------------------------------------------------------------------
module tb_async_hdlc_deframer_crc16;
	import ahdlc_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASE_OCTETS   = 100;
	localparam int NUM_PHASES     = 8;
	localparam int HOLD_OFF       = 400;
	localparam int MAX_PRINTS     = 40;
	localparam int NUM_ROWS       = 25;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

	typedef enum {FRAME_GOOD, FRAME_CORRUPT, FRAME_NOISE, FRAME_ESC_FLAG, FRAME_SHORT} frame_kind_t;

	typedef struct packed {
		logic [OCTET_W-1:0] octet;
		logic               typed;
		logic               has_res;
		result_t            res;
	} stim_row_t;

	localparam result_t NO_RESULT = '0;

	// typed rows carry their expected word, the rest go through the predictor
	localparam stim_row_t DIRECTED [NUM_ROWS] = '{
		'{FLAG_OCTET, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 11'd0}},
		'{8'h00,      1'b1, 1'b0, NO_RESULT},
		'{8'hFF,      1'b1, 1'b0, NO_RESULT},
		'{FLAG_OCTET, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 11'd2}},
		'{8'hFF,      1'b1, 1'b0, NO_RESULT},
		'{8'hFF,      1'b1, 1'b0, NO_RESULT},
		'{FLAG_OCTET, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 11'd2}},
		'{ESC_OCTET,  1'b1, 1'b0, NO_RESULT},
		'{8'hDF,      1'b1, 1'b0, NO_RESULT},
		'{ESC_OCTET,  1'b1, 1'b0, NO_RESULT},
		'{8'hDF,      1'b1, 1'b0, NO_RESULT},
		'{FLAG_OCTET, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 11'd2}},
		'{ESC_OCTET,  1'b1, 1'b0, NO_RESULT},
		'{FLAG_OCTET, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 11'd0}},
		'{ESC_OCTET,  1'b1, 1'b0, NO_RESULT},
		'{8'h5E,      1'b1, 1'b0, NO_RESULT},
		'{ESC_OCTET,  1'b1, 1'b0, NO_RESULT},
		'{8'h5D,      1'b1, 1'b0, NO_RESULT},
		'{ESC_OCTET,  1'b1, 1'b0, NO_RESULT},
		'{ESC_OCTET,  1'b1, 1'b1, '{1'b1, 8'h7E, 1'b0, 1'b0, 1'b0, 11'd0}},
		'{8'hA5,      1'b0, 1'b0, NO_RESULT},
		'{8'h5A,      1'b0, 1'b0, NO_RESULT},
		'{FLAG_OCTET, 1'b0, 1'b0, NO_RESULT},
		'{8'h80,      1'b0, 1'b0, NO_RESULT},
		'{FLAG_OCTET, 1'b0, 1'b0, NO_RESULT}
	};

	logic clk;
	logic arst_n;

	ahdlc_in_if  octets_if();
	ahdlc_out_if results_if();
	ahdlc_cfg_if cfg_if();

	async_hdlc_deframer_crc16 u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.octets  (octets_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	// predictor state and its copy of the registers
	logic [CRC_W-1:0]   cfg_crc_start;
	logic [LEN_W-1:0]   cfg_max_len;
	logic               esc_pending;
	logic [LEN_W-1:0]   stored_cnt;
	logic [CRC_W-1:0]   frame_crc;
	logic [OCTET_W-1:0] held_new;
	logic [OCTET_W-1:0] held_old;

	result_t pending_results[$];

	int tx_idle_pct;
	int rx_stall_pct;
	int rx_hold_request;
	bit need_flag;
	int idle_cycles;
	int n_errors;
	int n_octets;
	int n_bytes;
	int n_ends;
	int n_good;
	int n_aborts;
	int n_writes;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [CRC_W-1:0] crc16_fold(input logic [CRC_W-1:0] crc,
		input logic [OCTET_W-1:0] b);
		logic [CRC_W-1:0] c;
		int i;
		c = crc ^ {8'h00, b};
		for (i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// advances the deframer state by one line octet, returns 1 when a word is due
	function automatic bit deframe_octet(input logic [OCTET_W-1:0] raw, output result_t res);
		logic [OCTET_W-1:0] d;
		logic [LEN_W-1:0]   next_cnt;
		bit                 emit;
		logic [OCTET_W-1:0] emitted;
		res = '0;
		d = raw;
		emit = 1'b0;
		emitted = '0;
		if (raw == FLAG_OCTET) begin
			res.frame_end = 1'b1;
			res.frame_good = !esc_pending && stored_cnt >= FCS_LEN &&
				frame_crc == {held_new, held_old};
			res.frame_len = stored_cnt;
			esc_pending = 1'b0;
			stored_cnt = '0;
			frame_crc = cfg_crc_start;
			return 1'b1;
		end
		if (esc_pending) begin
			esc_pending = 1'b0;
			d = raw ^ ESC_XOR;
		end else if (raw == ESC_OCTET) begin
			esc_pending = 1'b1;
			return 1'b0;
		end
		if (stored_cnt >= FCS_LEN) begin
			emit = 1'b1;
			emitted = held_old;
			frame_crc = crc16_fold(frame_crc, held_old);
		end
		held_old = held_new;
		held_new = d;
		next_cnt = stored_cnt + 1'b1;
		res.has_byte = emit;
		res.out_byte = emitted;
		if (next_cnt >= cfg_max_len) begin
			stored_cnt = '0;
			frame_crc = cfg_crc_start;
			res.frame_abort = 1'b1;
			return 1'b1;
		end
		stored_cnt = next_cnt;
		return emit;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
	endtask

	task automatic send_octet(input logic [OCTET_W-1:0] octet, input bit predict = 1'b1);
		result_t res;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			octets_if.valid <= 1'b0;
			@(negedge clk);
		end
		octets_if.valid <= 1'b1;
		octets_if.in_octet <= octet;
		do @(posedge clk); while (octets_if.ready !== 1'b1);
		n_octets++;
		need_flag = (octet != FLAG_OCTET);
		if (deframe_octet(octet, res) && predict)
			pending_results.push_back(res);
	endtask

	task automatic send_line_byte(input logic [OCTET_W-1:0] b, input bit force_esc);
		if (b == FLAG_OCTET || b == ESC_OCTET || force_esc) begin
			send_octet(ESC_OCTET);
			send_octet(b ^ ESC_XOR);
		end else begin
			send_octet(b);
		end
	endtask

	task automatic send_frame(input frame_kind_t kind, input int payload_len);
		logic [OCTET_W-1:0] body[$];
		logic [OCTET_W-1:0] b;
		logic [CRC_W-1:0]   fcs;
		int                 pick;
		if (need_flag)
			send_octet(FLAG_OCTET);
		case (kind)
			FRAME_NOISE: begin
				repeat ($urandom_range(1, 10)) begin
					pick = $urandom_range(7);
					b = (pick == 0) ? ESC_OCTET : (pick == 1) ? FLAG_OCTET :
						8'($urandom_range(255));
					send_octet(b);
				end
			end
			FRAME_SHORT: begin
				repeat ($urandom_range(0, 1))
					send_line_byte(8'($urandom_range(255)), 1'b0);
				send_octet(FLAG_OCTET);
			end
			default: begin
				fcs = cfg_crc_start;
				repeat (payload_len) begin
					if ($urandom_range(9) == 0)
						b = $urandom_range(1) ? FLAG_OCTET : ESC_OCTET;
					else
						b = 8'($urandom_range(255));
					body.push_back(b);
					fcs = crc16_fold(fcs, b);
				end
				// fcs goes out low byte first
				body.push_back(fcs[7:0]);
				body.push_back(fcs[15:8]);
				if (kind == FRAME_CORRUPT) begin
					pick = $urandom_range(body.size() - 1);
					body[pick] = body[pick] ^ 8'(1 << $urandom_range(7));
				end
				foreach (body[k])
					send_line_byte(body[k], $urandom_range(19) == 0);
				if (kind == FRAME_ESC_FLAG)
					send_octet(ESC_OCTET);
				send_octet(FLAG_OCTET);
			end
		endcase
	endtask

	task automatic wait_drained();
		@(negedge clk);
		octets_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		n_writes++;
		case (idx)
			REG_CRC_START:  cfg_crc_start = data;
			REG_MAX_LENGTH: cfg_max_len = data[LEN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		// new crc_start only loads at the next flag or abort
		need_flag = 1'b1;
	endtask

	// result sink
	initial begin
		int hold_left;
		hold_left = 0;
		results_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_request > 0) begin
				hold_left = rx_hold_request;
				rx_hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
			got = '{results_if.has_byte, results_if.out_byte, results_if.frame_end,
				results_if.frame_good, results_if.frame_abort, results_if.frame_len};
			n_bytes += int'(got.has_byte);
			n_ends += int'(got.frame_end);
			n_good += int'(got.frame_good);
			n_aborts += int'(got.frame_abort);
			if (pending_results.size() == 0) begin
				report_mismatch("word with nothing expected", int'(got), 0);
			end else begin
				want = pending_results.pop_front();
				if (got.has_byte !== want.has_byte)
					report_mismatch("has_byte", int'(got.has_byte), int'(want.has_byte));
				if (got.out_byte !== want.out_byte)
					report_mismatch("out_byte", int'(got.out_byte), int'(want.out_byte));
				if (got.frame_end !== want.frame_end)
					report_mismatch("frame_end", int'(got.frame_end), int'(want.frame_end));
				if (got.frame_good !== want.frame_good)
					report_mismatch("frame_good", int'(got.frame_good), int'(want.frame_good));
				if (got.frame_abort !== want.frame_abort)
					report_mismatch("frame_abort", int'(got.frame_abort),
						int'(want.frame_abort));
				if (got.frame_len !== want.frame_len)
					report_mismatch("frame_len", int'(got.frame_len), int'(want.frame_len));
			end
		end
	end

	// counts cycles in which no word moves on any channel
	always @(posedge clk) begin
		if (!arst_n || (octets_if.valid === 1'b1 && octets_if.ready === 1'b1) ||
			(results_if.valid === 1'b1 && results_if.ready === 1'b1) ||
			(cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_async_hdlc_deframer_crc16: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int          r;
		int          phase;
		int          phase_start;
		int          plen;
		int          pick;
		bit          paused;
		frame_kind_t kind;
		arst_n = 1'b0;
		octets_if.valid = 1'b0;
		octets_if.in_octet = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_request = 0;
		paused = 1'b0;
		cfg_crc_start = CRC_START_RST;
		cfg_max_len = MAX_LENGTH_RST;
		esc_pending = 1'b0;
		stored_cnt = '0;
		frame_crc = CRC_START_RST;
		held_new = '0;
		held_old = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (r = 0; r < NUM_ROWS; r++) begin
			send_octet(DIRECTED[r].octet, !DIRECTED[r].typed);
			if (DIRECTED[r].typed && DIRECTED[r].has_res)
				pending_results.push_back(DIRECTED[r].res);
		end

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			wait_drained();
			case (phase % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 65; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 65; end
				default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
			endcase
			case (phase)
				0: begin
					cfg_write(REG_CRC_START, 16'h0000);
					cfg_write(REG_MAX_LENGTH, 16'd1024);
				end
				1: begin
					cfg_write(REG_MAX_LENGTH, 16'd3);
					cfg_write(REG_CRC_START, 16'hFFFF);
				end
				2: begin
					cfg_write(REG_CRC_START, 16'($urandom_range(16'hFFFF)));
					cfg_write(REG_MAX_LENGTH, 16'($urandom_range(3, 40)));
				end
				3: begin
					cfg_write(REG_CRC_START, 16'($urandom_range(16'hFFFF)));
					cfg_write(REG_MAX_LENGTH, 16'd256);
					cfg_write(REG_UNMAPPED_LO, 16'($urandom_range(16'hFFFF)));
					cfg_write(REG_UNMAPPED_HI, 16'($urandom_range(16'hFFFF)));
				end
				4: begin
					cfg_write(REG_CRC_START, 16'($urandom_range(16'hFFFF)));
					cfg_write(REG_MAX_LENGTH, 16'd4);
				end
				5: begin
					cfg_write(REG_CRC_START, 16'($urandom_range(16'hFFFF)));
					cfg_write(REG_MAX_LENGTH, 16'($urandom_range(3, 1024)));
				end
				6: begin
					cfg_write(REG_CRC_START, 16'($urandom_range(16'hFFFF)));
					cfg_write(REG_MAX_LENGTH, 16'($urandom_range(16, 200)));
				end
				default: begin
					cfg_write(REG_CRC_START, CRC_START_RST);
					cfg_write(REG_MAX_LENGTH, 16'(MAX_LENGTH_RST));
				end
			endcase
			// sink holds off while octets keep coming, so the block backs up
			if (phase == 5)
				rx_hold_request = HOLD_OFF;
			// one frame runs past the longest setting to hit the abort
			if (phase == 0)
				send_frame(FRAME_GOOD, cfg_max_len + 4);
			phase_start = n_octets;
			while (n_octets - phase_start < PHASE_OCTETS) begin
				if (phase == 6 && !paused && n_octets - phase_start >= PHASE_OCTETS / 2) begin
					wait_drained();
					paused = 1'b1;
				end
				pick = $urandom_range(99);
				kind = (pick < 60) ? FRAME_GOOD : (pick < 75) ? FRAME_CORRUPT :
					(pick < 85) ? FRAME_NOISE : (pick < 92) ? FRAME_ESC_FLAG : FRAME_SHORT;
				if (cfg_max_len < 16 && $urandom_range(1))
					plen = $urandom_range(0, cfg_max_len - 3);
				else if ($urandom_range(9) == 0)
					plen = $urandom_range(0, (cfg_max_len <= 64) ? cfg_max_len + 2 : 48);
				else
					plen = $urandom_range(0, 12);
				send_frame(kind, plen);
			end
		end

		wait_drained();
		$display("covered %0d line octets: %0d payload bytes, %0d frame ends (%0d good), %0d aborts",
			n_octets, n_bytes, n_ends, n_good, n_aborts);
		$display("%0d register writes over %0d settings, %0d mismatches",
			n_writes, NUM_PHASES + 1, n_errors);
		if (n_errors == 0)
			$display("tb_async_hdlc_deframer_crc16: clean");
		else
			$display("tb_async_hdlc_deframer_crc16: errors");
		$finish;
	end

endmodule
